// ===== design/ssr_pkg.sv =====
// Shared types and constants for the stream substring replace block.
// No dependencies; compile first.
package ssr_pkg;

  localparam int BYTE_W      = 8;
  localparam int TALLY_W     = 24;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;
  localparam int PAT_LEN_W   = 4;
  localparam int REPL_BYTES  = 8;
  localparam int REPL_LEN_W  = 4;
  localparam int REPL_IDX_W  = 3;
  localparam int LIMIT_W     = 16;

  localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_WORD = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_LEN  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_ENABLE     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_COUNT      = 3'd5;

  typedef struct packed {
    logic accept;
    logic shift;
    logic replace;
    logic emit_repl;
    logic emit_bare;
    logic last;
  } ssr_cmd_t;

  typedef struct packed {
    logic match_full;
    logic match_part;
    logic count_zero;
    logic count_one;
    logic repl_empty;
    logic repl_last;
    logic out_free;
  } ssr_status_t;

endpackage

// ===== design/ssr_if.sv =====
// Stream interfaces for text items in and result items out.
// Depends on ssr_pkg.
interface ssr_text_if;
  logic                      valid;
  logic                      ready;
  logic [ssr_pkg::BYTE_W-1:0] text_byte;
  logic                      end_of_text;

  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface ssr_result_if;
  logic                        valid;
  logic                        ready;
  logic [ssr_pkg::BYTE_W-1:0]  out_byte;
  logic                        byte_valid;
  logic                        out_last;
  logic [ssr_pkg::TALLY_W-1:0] replacements_made;
  logic [ssr_pkg::TALLY_W-1:0] output_length;

  modport source (output valid, out_byte, byte_valid, out_last, replacements_made,
                  output_length, input ready);
  modport sink   (input valid, out_byte, byte_valid, out_last, replacements_made,
                  output_length, output ready);
endinterface

// ===== design/ssr_datapath.sv =====
// Datapath: config registers, pending byte buffer, prefix compare, tallies
// and the output register. Driven by ssr_controller; depends on ssr_pkg.
module ssr_datapath #(
  parameter int PATTERN_BYTES = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ssr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ssr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [ssr_pkg::BYTE_W-1:0]          text_byte,
  input  ssr_pkg::ssr_cmd_t                   cmd,
  output ssr_pkg::ssr_status_t                status,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [ssr_pkg::BYTE_W-1:0]          out_byte,
  output logic                                byte_valid,
  output logic                                out_last,
  output logic [ssr_pkg::TALLY_W-1:0]         replacements_made,
  output logic [ssr_pkg::TALLY_W-1:0]         output_length
);

  localparam int CW = $clog2(PATTERN_BYTES + 1);
  localparam int PW = PATTERN_BYTES * ssr_pkg::BYTE_W;
  localparam int RW = ssr_pkg::REPL_BYTES * ssr_pkg::BYTE_W;

  logic [ssr_pkg::CFG_DATA_W-1:0]  pattern_word;
  logic [ssr_pkg::PAT_LEN_W-1:0]   pattern_len;
  logic [RW-1:0]                   replacement_word;
  logic [ssr_pkg::REPL_LEN_W-1:0]  replacement_len;
  logic                            limit_enable;
  logic [ssr_pkg::LIMIT_W-1:0]     limit_count;

  logic [PW-1:0]                   act_pattern;
  logic [CW-1:0]                   act_len;
  logic [CW-1:0]                   load_len;
  logic [ssr_pkg::BYTE_W-1:0]      pend [PATTERN_BYTES];
  logic [CW-1:0]                   count;
  logic [ssr_pkg::REPL_IDX_W-1:0]  ridx;
  logic [ssr_pkg::REPL_LEN_W-1:0]  repl_len_eff;
  logic [ssr_pkg::TALLY_W-1:0]     replace_tally;
  logic [ssr_pkg::TALLY_W-1:0]     emitted_tally;
  logic [ssr_pkg::TALLY_W-1:0]     emitted_next;
  logic                            allowed;
  logic                            prefix;
  logic                            emit;
  logic                            emit_valid;
  logic [ssr_pkg::BYTE_W-1:0]      emit_byte;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_word     <= '0;
      pattern_len      <= ssr_pkg::PAT_LEN_W'(1);
      replacement_word <= '0;
      replacement_len  <= '0;
      limit_enable     <= 1'b0;
      limit_count      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ssr_pkg::REG_PATTERN_WORD:     pattern_word     <= cfg_data;
        ssr_pkg::REG_PATTERN_LEN:      pattern_len      <= cfg_data[ssr_pkg::PAT_LEN_W-1:0];
        ssr_pkg::REG_REPLACEMENT_WORD: replacement_word <= cfg_data[RW-1:0];
        ssr_pkg::REG_REPLACEMENT_LEN:  replacement_len  <= cfg_data[ssr_pkg::REPL_LEN_W-1:0];
        ssr_pkg::REG_LIMIT_ENABLE:     limit_enable     <= cfg_data[0];
        ssr_pkg::REG_LIMIT_COUNT:      limit_count      <= cfg_data[ssr_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pattern_len == '0) begin
      load_len = CW'(1);
    end else if (int'(pattern_len) > PATTERN_BYTES) begin
      load_len = CW'(PATTERN_BYTES);
    end else begin
      load_len = CW'(pattern_len);
    end
  end

  assign repl_len_eff = (int'(replacement_len) > ssr_pkg::REPL_BYTES)
                      ? ssr_pkg::REPL_LEN_W'(ssr_pkg::REPL_BYTES) : replacement_len;

  assign allowed = !limit_enable || (replace_tally < ssr_pkg::TALLY_W'(limit_count));

  always_comb begin
    prefix = (count <= act_len);
    for (int i = 0; i < PATTERN_BYTES; i++) begin
      if (CW'(i) < count && pend[i] != act_pattern[i*ssr_pkg::BYTE_W +: ssr_pkg::BYTE_W]) begin
        prefix = 1'b0;
      end
    end
  end

  always_comb begin
    status.match_full = allowed && prefix && (count == act_len);
    status.match_part = allowed && prefix;
    status.count_zero = (count == '0);
    status.count_one  = (count == CW'(1));
    status.repl_empty = (repl_len_eff == '0);
    status.repl_last  = (ssr_pkg::REPL_LEN_W'(ridx) + ssr_pkg::REPL_LEN_W'(1)) == repl_len_eff;
    status.out_free   = !out_valid || out_ready;
  end

  // pending buffer and active pattern
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      for (int i = 0; i < PATTERN_BYTES; i++) begin
        if (CW'(i) == count) begin
          pend[i] <= text_byte;
        end
      end
      if (count == '0) begin
        act_pattern <= pattern_word[PW-1:0];
        act_len     <= load_len;
      end
    end else if (cmd.shift) begin
      for (int i = 0; i < PATTERN_BYTES - 1; i++) begin
        pend[i] <= pend[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.accept) begin
      count <= count + CW'(1);
    end else if (cmd.shift) begin
      count <= count - CW'(1);
    end else if (cmd.replace) begin
      count <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.replace) begin
      ridx <= '0;
    end else if (cmd.emit_repl) begin
      ridx <= ridx + ssr_pkg::REPL_IDX_W'(1);
    end
  end

  assign emit       = cmd.shift || cmd.emit_repl || cmd.emit_bare;
  assign emit_valid = cmd.shift || cmd.emit_repl;

  always_comb begin
    if (cmd.shift) begin
      emit_byte = pend[0];
    end else if (cmd.emit_repl) begin
      emit_byte = replacement_word[ridx*ssr_pkg::BYTE_W +: ssr_pkg::BYTE_W];
    end else begin
      emit_byte = '0;
    end
  end

  assign emitted_next = (emit_valid && emitted_tally != ssr_pkg::TALLY_MAX)
                      ? emitted_tally + ssr_pkg::TALLY_W'(1) : emitted_tally;

  // tallies clear once the last item of a text is out
  always_ff @(posedge clk) begin
    if (rst) begin
      replace_tally <= '0;
      emitted_tally <= '0;
    end else if (cmd.last) begin
      replace_tally <= '0;
      emitted_tally <= '0;
    end else begin
      if (cmd.replace && replace_tally != ssr_pkg::TALLY_MAX) begin
        replace_tally <= replace_tally + ssr_pkg::TALLY_W'(1);
      end
      if (emit) begin
        emitted_tally <= emitted_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte          <= emit_byte;
      byte_valid        <= emit_valid;
      out_last          <= cmd.last;
      replacements_made <= replace_tally;
      output_length     <= emitted_next;
    end
  end

endmodule

// ===== design/ssr_controller.sv =====
// Controller: sequences accept, match evaluation, replacement output and
// end-of-text flush. Drives ssr_datapath by command; depends on ssr_pkg.
module ssr_controller (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_end,
  output logic                  in_ready,
  input  ssr_pkg::ssr_status_t  status,
  output ssr_pkg::ssr_cmd_t     cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVAL  = 2'd1;
  localparam logic [1:0] S_REPL  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       end_flag;
  logic       emitted;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (status.match_full) begin
          cmd.replace = 1'b1;
          if (!status.repl_empty) begin
            state_next = S_REPL;
          end else begin
            state_next = end_flag ? S_FLUSH : S_IDLE;
          end
        end else if (status.match_part) begin
          state_next = end_flag ? S_FLUSH : S_IDLE;
        end else if (status.out_free) begin
          cmd.shift = 1'b1;
          cmd.last  = end_flag && status.count_one;
          if (status.count_one) begin
            state_next = S_IDLE;
          end
        end
      end
      S_REPL: begin
        if (status.out_free) begin
          cmd.emit_repl = 1'b1;
          cmd.last      = end_flag && status.repl_last;
          if (status.repl_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (status.count_zero) begin
          if (emitted) begin
            state_next = S_IDLE;
          end else if (status.out_free) begin
            cmd.emit_bare = 1'b1;
            cmd.last      = 1'b1;
            state_next    = S_IDLE;
          end
        end else if (status.out_free) begin
          cmd.shift = 1'b1;
          cmd.last  = status.count_one;
          if (status.count_one) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      emitted <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.accept) begin
        emitted <= 1'b0;
      end else if (cmd.shift || cmd.emit_repl || cmd.emit_bare) begin
        emitted <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      end_flag <= in_end;
    end
  end

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.shift || cmd.emit_repl || cmd.emit_bare) |-> status.out_free)
    else $error("item emitted while output register full");

  a_one_action: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.shift, cmd.replace, cmd.emit_repl, cmd.emit_bare}))
    else $error("more than one datapath action in a cycle");

  a_last_only_at_end: assert property (@(posedge clk) disable iff (rst)
    cmd.last |-> end_flag && (cmd.shift || cmd.emit_repl || cmd.emit_bare))
    else $error("last marker outside end of text");

  a_repl_buffer_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_REPL |-> status.count_zero)
    else $error("pending bytes held during replacement output");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.last |=> state == S_IDLE)
    else $error("controller busy after last item");

endmodule

// ===== design/stream_substring_replace.sv =====
// Each accepted text byte goes through an accept step, then match evaluation
// against the pending buffer. The single output register takes one byte per
// cycle unless output backpressure holds it. A match leads to the replacement
// bytes being output one by one, and an end-of-text flush outputs each pending
// byte in turn, or a bare end item. The pending buffer is PATTERN_BYTES deep
// and needs no clearing after reset.
// Top level; depends on ssr_pkg, ssr_if, ssr_controller and ssr_datapath.
module stream_substring_replace #(
  parameter int PATTERN_BYTES = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ssr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ssr_pkg::CFG_DATA_W-1:0]  cfg_data,
  ssr_text_if.sink                        text,
  ssr_result_if.source                    result
);

  ssr_pkg::ssr_cmd_t    cmd;
  ssr_pkg::ssr_status_t status;

  ssr_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (text.valid),
    .in_end   (text.end_of_text),
    .in_ready (text.ready),
    .status   (status),
    .cmd      (cmd)
  );

  ssr_datapath #(
    .PATTERN_BYTES (PATTERN_BYTES)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .text_byte         (text.text_byte),
    .cmd               (cmd),
    .status            (status),
    .out_ready         (result.ready),
    .out_valid         (result.valid),
    .out_byte          (result.out_byte),
    .byte_valid        (result.byte_valid),
    .out_last          (result.out_last),
    .replacements_made (result.replacements_made),
    .output_length     (result.output_length)
  );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for stream_substring_replace: directed table, then random texts,
// each result item checked against an in-bench find-and-replace predictor or a
// typed expected item. Depends on ssr_pkg, ssr_if and the design files.
module testbench;

  typedef struct packed {
    logic [7:0]  byte_val;
    logic        has_byte;
    logic        is_last;
    logic [23:0] reps;
    logic [23:0] olen;
  } res_t;

  typedef struct packed {
    bit          is_cfg;
    logic [2:0]  idx;
    logic [63:0] data;
    logic [7:0]  b;
    logic        e;
    bit          typed;
    res_t        want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  ssr_text_if   txt();
  ssr_result_if res();

  stream_substring_replace uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .text(txt), .result(res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register shadows
  logic [63:0] pat_word = '0;
  logic [3:0]  pat_len = 4'd1;
  logic [63:0] rep_word = '0;
  logic [3:0]  rep_len = '0;
  logic        lim_en = 1'b0;
  logic [15:0] lim_cnt = '0;

  // matcher state
  logic [7:0]  hold_bytes [8];
  int          hold_cnt = 0;
  logic [23:0] rep_tally = '0;
  logic [23:0] out_tally = '0;
  logic [63:0] live_pat = '0;
  int          live_len = 1;

  res_t step_out [$];
  res_t owed_out [$];
  row_t plan [$];
  int   errors = 0;
  int   sent = 0;
  bit   gaps = 1'b1;
  bit   backlog_req = 1'b0;
  int   stall_left = 0;

  function automatic int eff_len(input logic [3:0] v);
    if (v == 0) return 1;
    if (v > 8) return 8;
    return v;
  endfunction

  function automatic void emit(input logic [7:0] b, input logic v);
    res_t r;
    if (v && out_tally != ssr_pkg::TALLY_MAX) out_tally++;
    r.byte_val = b;
    r.has_byte = v;
    r.is_last = 1'b0;
    r.reps = rep_tally;
    r.olen = out_tally;
    step_out.push_back(r);
  endfunction

  function automatic void shift_hold();
    emit(hold_bytes[0], 1'b1);
    for (int i = 1; i < 8; i++) hold_bytes[i-1] = hold_bytes[i];
    hold_cnt--;
  endfunction

  function automatic void replace_step(input logic [7:0] b, input logic e);
    bit ok;
    bit pre;
    int rl;
    step_out.delete();
    if (hold_cnt == 0) begin
      live_pat = pat_word;
      live_len = eff_len(pat_len);
    end
    if (hold_cnt < 8) begin
      hold_bytes[hold_cnt] = b;
      hold_cnt++;
    end
    while (hold_cnt > 0) begin
      ok = !lim_en || rep_tally < {8'd0, lim_cnt};
      pre = hold_cnt <= live_len;
      for (int i = 0; i < hold_cnt; i++)
        if (hold_bytes[i] != live_pat[8*i +: 8]) pre = 1'b0;
      if (ok && pre && hold_cnt == live_len) begin
        rl = rep_len > 8 ? 8 : rep_len;
        if (rep_tally != ssr_pkg::TALLY_MAX) rep_tally++;
        hold_cnt = 0;
        for (int i = 0; i < rl; i++) emit(rep_word[8*i +: 8], 1'b1);
        break;
      end
      if (ok && pre) break;
      shift_hold();
    end
    if (e) begin
      while (hold_cnt > 0) shift_hold();
      if (step_out.size() == 0) emit(8'h00, 1'b0);
      step_out[step_out.size()-1].is_last = 1'b1;
      rep_tally = '0;
      out_tally = '0;
    end
  endfunction

  function automatic void add_cfg(input logic [2:0] idx, input logic [63:0] val);
    row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = val;
    plan.push_back(r);
  endfunction

  function automatic void add_byte(input logic [7:0] b, input logic e, input bit typed,
                                   input res_t want);
    row_t r;
    r = '0;
    r.b = b;
    r.e = e;
    r.typed = typed;
    r.want = want;
    plan.push_back(r);
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      ssr_pkg::REG_PATTERN_WORD:     pat_word = val;
      ssr_pkg::REG_PATTERN_LEN:      pat_len = val[3:0];
      ssr_pkg::REG_REPLACEMENT_WORD: rep_word = val;
      ssr_pkg::REG_REPLACEMENT_LEN:  rep_len = val[3:0];
      ssr_pkg::REG_LIMIT_ENABLE:     lim_en = val[0];
      ssr_pkg::REG_LIMIT_COUNT:      lim_cnt = val[15:0];
      default: ;
    endcase
  endtask

  // wait for all owed items, then let buffered bytes finish evaluating
  task automatic settle();
    txt.valid <= 1'b0;
    while (owed_out.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic e, input bit typed,
                           input res_t want);
    while (gaps && $urandom_range(99) < 19) begin
      txt.valid <= 1'b0;
      @(posedge clk);
    end
    txt.valid <= 1'b1;
    txt.text_byte <= b;
    txt.end_of_text <= e;
    @(posedge clk);
    while (!txt.ready) @(posedge clk);
    sent++;
    replace_step(b, e);
    if (typed) owed_out.push_back(want);
    else foreach (step_out[i]) owed_out.push_back(step_out[i]);
  endtask

  task automatic send_text(input int n, input bit close);
    int plen;
    int k;
    int m;
    logic [7:0] chars [$];
    plen = eff_len(pat_len);
    while (chars.size() < n) begin
      k = $urandom_range(99);
      if (k < 35) begin
        for (int i = 0; i < plen; i++) chars.push_back(pat_word[8*i +: 8]);
      end else if (k < 55 && plen > 1) begin
        m = $urandom_range(plen - 1, 1);
        for (int i = 0; i < m; i++) chars.push_back(pat_word[8*i +: 8]);
      end else if (k < 85) begin
        chars.push_back(pat_word[8*$urandom_range(plen - 1) +: 8]);
      end else begin
        chars.push_back(8'($urandom));
      end
    end
    foreach (chars[i]) send_byte(chars[i], close && i == chars.size() - 1, 1'b0, '0);
  endtask

  task automatic pick_regs();
    logic [63:0] w;
    int k;
    k = $urandom_range(99);
    for (int i = 0; i < 8; i++) w[8*i +: 8] = 8'h41 + 8'($urandom_range(3));
    if (k >= 75 && k < 85) w = '1;
    else if (k >= 85 && k < 90) w = '0;
    else if (k >= 90) w = {$urandom, $urandom};
    write_reg(ssr_pkg::REG_PATTERN_WORD, w);
    if ($urandom_range(99) < 85)
      write_reg(ssr_pkg::REG_PATTERN_LEN, 64'($urandom_range(8, 1)));
    else if ($urandom_range(1)) write_reg(ssr_pkg::REG_PATTERN_LEN, 64'd0);
    else write_reg(ssr_pkg::REG_PATTERN_LEN, 64'($urandom_range(15, 9)));
    write_reg(ssr_pkg::REG_REPLACEMENT_WORD, {$urandom, $urandom});
    if ($urandom_range(99) < 90)
      write_reg(ssr_pkg::REG_REPLACEMENT_LEN, 64'($urandom_range(8)));
    else write_reg(ssr_pkg::REG_REPLACEMENT_LEN, 64'($urandom_range(15, 9)));
    write_reg(ssr_pkg::REG_LIMIT_ENABLE, 64'($urandom_range(99) < 30));
    k = $urandom_range(99);
    if (k < 50) write_reg(ssr_pkg::REG_LIMIT_COUNT, 64'($urandom_range(4)));
    else if (k < 60) write_reg(ssr_pkg::REG_LIMIT_COUNT, 64'hFFFF);
    else write_reg(ssr_pkg::REG_LIMIT_COUNT, 64'($urandom_range(16'hFFFF)));
  endtask

  task automatic check_result();
    res_t got;
    res_t want;
    got = {res.out_byte, res.byte_valid, res.out_last, res.replacements_made,
           res.output_length};
    if (owed_out.size() == 0) begin
      errors++;
      $display("%0t: unexpected result item %h", $time, got);
      return;
    end
    want = owed_out.pop_front();
    if (got.byte_val !== want.byte_val) begin
      errors++;
      $display("%0t: out_byte expected %h got %h", $time, want.byte_val, got.byte_val);
    end
    if (got.has_byte !== want.has_byte) begin
      errors++;
      $display("%0t: byte_valid expected %b got %b", $time, want.has_byte, got.has_byte);
    end
    if (got.is_last !== want.is_last) begin
      errors++;
      $display("%0t: out_last expected %b got %b", $time, want.is_last, got.is_last);
    end
    if (got.reps !== want.reps) begin
      errors++;
      $display("%0t: replacements_made expected %0d got %0d", $time, want.reps, got.reps);
    end
    if (got.olen !== want.olen) begin
      errors++;
      $display("%0t: output_length expected %0d got %0d", $time, want.olen, got.olen);
    end
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res.valid && res.ready) check_result();
      if (backlog_req) begin
        backlog_req = 1'b0;
        stall_left = 250;
      end
      if (stall_left > 0) begin
        stall_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= !(gaps && $urandom_range(99) < 19);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= ssr_pkg::REG_PATTERN_WORD;
    cfg_data <= '0;
    txt.valid <= 1'b0;
    txt.text_byte <= '0;
    txt.end_of_text <= 1'b0;
    foreach (hold_bytes[i]) hold_bytes[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    add_byte(8'h00, 1'b1, 1'b1, res_t'{8'h00, 1'b0, 1'b1, 24'd1, 24'd0});
    add_byte(8'hFF, 1'b1, 1'b1, res_t'{8'hFF, 1'b1, 1'b1, 24'd0, 24'd1});
    add_cfg(ssr_pkg::REG_PATTERN_WORD, 64'h636261);
    add_cfg(ssr_pkg::REG_PATTERN_LEN, 64'd3);
    add_cfg(ssr_pkg::REG_REPLACEMENT_WORD, 64'h5958);
    add_cfg(ssr_pkg::REG_REPLACEMENT_LEN, 64'd2);
    add_byte(8'h61, 1'b0, 1'b0, '0);
    add_byte(8'h62, 1'b0, 1'b0, '0);
    add_byte(8'h63, 1'b0, 1'b0, '0);
    add_byte(8'h61, 1'b0, 1'b0, '0);
    add_byte(8'h62, 1'b1, 1'b0, '0);
    // length zero reads as one, over eight reads as eight
    add_cfg(ssr_pkg::REG_PATTERN_WORD, '1);
    add_cfg(ssr_pkg::REG_PATTERN_LEN, 64'd0);
    add_cfg(ssr_pkg::REG_REPLACEMENT_WORD, 64'h0123456789ABCDEF);
    add_cfg(ssr_pkg::REG_REPLACEMENT_LEN, 64'd15);
    add_byte(8'hFF, 1'b0, 1'b0, '0);
    add_byte(8'h00, 1'b1, 1'b0, '0);
    add_cfg(ssr_pkg::REG_PATTERN_WORD, 64'h8877665544332211);
    add_cfg(ssr_pkg::REG_PATTERN_LEN, 64'd15);
    for (int i = 1; i <= 8; i++) add_byte(8'(8'h11 * i), i == 8, 1'b0, '0);
    add_cfg(ssr_pkg::REG_LIMIT_ENABLE, 64'd1);
    add_cfg(ssr_pkg::REG_LIMIT_COUNT, 64'd0);
    add_byte(8'h11, 1'b1, 1'b1, res_t'{8'h11, 1'b1, 1'b1, 24'd0, 24'd1});
    add_cfg(ssr_pkg::REG_PATTERN_WORD, 64'h61);
    add_cfg(ssr_pkg::REG_PATTERN_LEN, 64'd1);
    add_cfg(ssr_pkg::REG_REPLACEMENT_LEN, 64'd0);
    add_cfg(ssr_pkg::REG_LIMIT_COUNT, 64'd1);
    add_byte(8'h61, 1'b0, 1'b0, '0);
    add_byte(8'h61, 1'b0, 1'b1, res_t'{8'h61, 1'b1, 1'b0, 24'd1, 24'd1});
    add_byte(8'h61, 1'b1, 1'b1, res_t'{8'h61, 1'b1, 1'b1, 24'd1, 24'd2});
    add_cfg(ssr_pkg::REG_LIMIT_COUNT, 64'hFFFF);
    add_byte(8'h61, 1'b0, 1'b0, '0);
    add_byte(8'h61, 1'b1, 1'b1, res_t'{8'h00, 1'b0, 1'b1, 24'd2, 24'd0});

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (i == 0 || !plan[i-1].is_cfg) settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_byte(plan[i].b, plan[i].e, plan[i].typed, plan[i].want);
      end
    end

    settle();
    pick_regs();
    backlog_req = 1'b1;
    send_text(24, 1'b1);
    while (sent < 195) begin
      gaps = !(sent >= 110 && sent < 165);
      settle();
      pick_regs();
      repeat ($urandom_range(3, 1)) send_text($urandom_range(14, 1), $urandom_range(99) < 85);
    end
    send_byte(8'($urandom), 1'b1, 1'b0, '0);

    txt.valid <= 1'b0;
    while (owed_out.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
